/* src/tocap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tocap_pkg
// shared types, codes and constants of the text overlay register capture block
// ----------------------------------------------------------------------------
package tocap_pkg;

    localparam int SHADOW_BYTES = 49152;
    localparam int SHADOW_DEPTH = 2 * SHADOW_BYTES;
    localparam int ADDR_W       = $clog2(SHADOW_DEPTH);
    localparam int POS_W        = 16;
    localparam int CNT_W        = 17;
    localparam int DELAY_W      = 20;
    localparam int CYCLE_W      = 64;
    localparam int GEN_W        = 32;
    localparam int IN_DATA_W    = 128;
    localparam int OUT_DATA_W   = 72;

    // item kinds
    localparam logic [2:0] KIND_REG_READ  = 3'd0;
    localparam logic [2:0] KIND_REG_WRITE = 3'd1;
    localparam logic [2:0] KIND_SNOOP     = 3'd2;
    localparam logic [2:0] KIND_GAP       = 3'd3;
    localparam logic [2:0] KIND_FRAME     = 3'd4;
    localparam logic [2:0] KIND_CELL_READ = 3'd5;

    // card register offsets
    localparam logic [3:0] OFF_INDEX    = 4'd0;
    localparam logic [3:0] OFF_DATA     = 4'd1;
    localparam logic [3:0] OFF_DATA_INC = 4'd2;
    localparam logic [3:0] OFF_CMD      = 4'd3;
    localparam logic [3:0] OFF_STATUS   = 4'd4;

    // command bytes
    localparam logic [7:0] CMD_OFF  = 8'd0;
    localparam logic [7:0] CMD_ARM  = 8'd1;
    localparam logic [7:0] CMD_SHOW = 8'd2;
    localparam logic [7:0] CMD_HIDE = 8'd3;

    // indexed registers
    localparam logic [7:0] IX_BASE_LO   = 8'h00;
    localparam logic [7:0] IX_BASE_HI   = 8'h01;
    localparam logic [7:0] IX_CFG       = 8'h02;
    localparam logic [7:0] IX_COLS      = 8'h03;
    localparam logic [7:0] IX_ROWS      = 8'h04;
    localparam logic [7:0] IX_X_LO      = 8'h05;
    localparam logic [7:0] IX_X_HI      = 8'h06;
    localparam logic [7:0] IX_Y_LO      = 8'h07;
    localparam logic [7:0] IX_Y_HI      = 8'h08;
    localparam logic [7:0] IX_SCALE     = 8'h09;
    localparam logic [7:0] IX_CUR_COL   = 8'h0A;
    localparam logic [7:0] IX_CUR_ROW   = 8'h0B;
    localparam logic [7:0] IX_CUR_MODE  = 8'h0C;
    localparam logic [7:0] IX_FILL_CHAR = 8'h0D;
    localparam logic [7:0] IX_FILL_ATTR = 8'h0E;
    localparam logic [7:0] IX_WIDTH_LO  = 8'h10;
    localparam logic [7:0] IX_WIDTH_HI  = 8'h11;
    localparam logic [7:0] IX_HEIGHT_LO = 8'h12;
    localparam logic [7:0] IX_HEIGHT_HI = 8'h13;
    localparam logic [7:0] IX_A_BASE_LO = 8'h14;
    localparam logic [7:0] IX_A_BASE_HI = 8'h15;
    localparam logic [7:0] IX_A_CFG     = 8'h16;
    localparam logic [7:0] IX_A_COLS    = 8'h17;
    localparam logic [7:0] IX_A_ROWS    = 8'h18;
    localparam logic [7:0] IX_A_X_LO    = 8'h19;
    localparam logic [7:0] IX_A_X_HI    = 8'h1A;
    localparam logic [7:0] IX_A_Y_LO    = 8'h1B;
    localparam logic [7:0] IX_A_Y_HI    = 8'h1C;
    localparam logic [7:0] IX_A_SCALE   = 8'h1D;
    localparam logic [7:0] IX_INFO      = 8'h1E;

    localparam logic [7:0]  INFO_BYTE     = 8'h7F;
    localparam logic [15:0] BASE_MIN      = 16'h0200;
    localparam logic [7:0]  CFG_RSVD_MASK = 8'hE0;
    localparam logic [7:0]  ROWS_MAX      = 8'h7F;
    localparam logic [31:0] ADDR_HI_MASK  = 32'hFFFE0000;

    localparam logic [10:0] WIDTH_WIDE    = 11'd1280;
    localparam logic [10:0] WIDTH_NARROW  = 11'd1120;
    localparam logic [9:0]  HEIGHT_WIDE   = 10'd800;
    localparam logic [9:0]  HEIGHT_NARROW = 10'd768;

    localparam logic [7:0] ID_BYTES [8] = '{8'h4C, 8'h49, 8'h4E, 8'h54,
                                            8'h58, 8'h54, 8'h4C, 8'h10};

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_OFF  = 2'd1,
        ACT_SHOW = 2'd2,
        ACT_HIDE = 2'd3
    } act_t;

    typedef struct packed {
        logic [15:0] base;
        logic [7:0]  cfg;
        logic [7:0]  cols;
        logic [7:0]  rows;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  scale;
        logic [7:0]  fill_char;
        logic [7:0]  fill_attr;
    } setup_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_ACT,
        ST_MEM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic finish;
        logic fill;
        logic act;
        logic mem_done;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic finish_due;
        logic fill_ok;
        logic fill_last;
        logic mem_needed;
    } dp_status_t;

endpackage

/* src/tocap_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tocap_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tocap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/tocap_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tocap_ctrl
// sequencer: capture, busy finish, fill sweep, action, memory access, output
// ----------------------------------------------------------------------------
module tocap_ctrl
    import tocap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: state_next = (status.finish_due && status.fill_ok) ? ST_FILL : ST_ACT;
            ST_FILL: if (status.fill_last) state_next = ST_ACT;
            ST_ACT:  state_next = status.mem_needed ? ST_MEM : ST_DONE;
            ST_MEM:  state_next = ST_DONE;
            ST_DONE: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: cmd.finish   = status.finish_due;
            ST_FILL: cmd.fill     = 1'b1;
            ST_ACT:  cmd.act      = 1'b1;
            ST_MEM:  cmd.mem_done = 1'b1;
            ST_DONE: cmd.out_load = !m_tvalid_reg || m_tready;
            default: cmd = '0;
        endcase
    end

    assign m_tvalid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    assign m_tvalid      = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* src/tocap_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tocap_datapath
// card registers, setup copies, flags, shadow memory and result register
// ----------------------------------------------------------------------------
module tocap_datapath
    import tocap_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic [2:0]            kind,
    input  logic [3:0]            offset,
    input  logic [7:0]            value,
    input  logic [31:0]           address,
    input  logic [CYCLE_W-1:0]    cycle,
    input  logic                  wide_canvas,
    input  logic                  blink_phase,
    input  logic [15:0]           cell_index,
    input  logic                  cfg_wr_en,
    input  logic [DELAY_W-1:0]    cfg_wr_data,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    function automatic logic [ADDR_W-1:0] slot_addr(input logic slot,
                                                    input logic [POS_W-1:0] pos);
        slot_addr = ADDR_W'(pos) + (slot ? ADDR_W'(SHADOW_BYTES) : ADDR_W'(0));
    endfunction

    // item registers
    logic [2:0]         kind_reg;
    logic [3:0]         off_reg;
    logic [7:0]         val_reg;
    logic [31:0]        addr_reg;
    logic [CYCLE_W-1:0] cyc_reg;
    logic               wide_in_reg;
    logic               blink_in_reg;
    logic [15:0]        cidx_reg;

    logic [DELAY_W-1:0] arm_delay_reg;

    logic [7:0]         reg_index_reg, reg_index_next;
    setup_t             staged_reg, staged_next;
    setup_t             prep_reg, prep_next;
    setup_t             armed_set_reg, armed_set_next;
    setup_t             active_reg, active_next;
    logic [7:0]         cur_col_reg, cur_col_next;
    logic [6:0]         cur_row_reg, cur_row_next;
    logic [3:0]         cur_mode_reg, cur_mode_next;
    logic               busy_reg, busy_next;
    logic               stale_reg, stale_next;
    logic               error_reg, error_next;
    logic               armed_reg, armed_next;
    logic               visible_reg, visible_next;
    logic               dirty_reg, dirty_next;
    logic               blink_reg, blink_next;
    logic               armed_slot_reg, armed_slot_next;
    logic               active_slot_reg, active_slot_next;
    act_t               pending_reg, pending_next;
    logic [CYCLE_W-1:0] ready_reg, ready_next;
    logic               wide_reg, wide_next;
    logic [GEN_W-1:0]   gen_reg, gen_next;
    logic [CNT_W-1:0]   prep_count_reg, prep_count_next;
    logic [CNT_W-1:0]   armed_count_reg, armed_count_next;
    logic [POS_W-1:0]   fill_cnt_reg, fill_cnt_next;
    logic [ADDR_W-1:0]  snoop_addr_reg, snoop_addr_next;
    logic [7:0]         rd_reg, rd_next;
    logic               redraw_reg, redraw_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [10:0] cur_width;
    logic [9:0]  cur_height;
    logic [5:0]  status_now;
    logic [7:0]  idx_val;
    logic [7:0]  read_val;
    logic        overflow;
    logic        snoop_hit;
    logic        cell_ok;
    logic [15:0] snoop_lo;
    logic [POS_W-1:0] snoop_pos;
    logic [15:0] arm_prod;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    assign cur_width  = wide_reg ? WIDTH_WIDE : WIDTH_NARROW;
    assign cur_height = wide_reg ? HEIGHT_WIDE : HEIGHT_NARROW;
    assign status_now = {busy_reg, stale_reg, error_reg, pending_reg != ACT_NONE,
                         armed_reg, visible_reg};

    // indexed register read
    always_comb
    begin
        unique case (reg_index_reg)
            IX_BASE_LO:   idx_val = staged_reg.base[7:0];
            IX_BASE_HI:   idx_val = staged_reg.base[15:8];
            IX_CFG:       idx_val = staged_reg.cfg;
            IX_COLS:      idx_val = staged_reg.cols;
            IX_ROWS:      idx_val = staged_reg.rows;
            IX_X_LO:      idx_val = staged_reg.x[7:0];
            IX_X_HI:      idx_val = staged_reg.x[15:8];
            IX_Y_LO:      idx_val = staged_reg.y[7:0];
            IX_Y_HI:      idx_val = staged_reg.y[15:8];
            IX_SCALE:     idx_val = staged_reg.scale;
            IX_CUR_COL:   idx_val = cur_col_reg;
            IX_CUR_ROW:   idx_val = {1'b0, cur_row_reg};
            IX_CUR_MODE:  idx_val = {4'd0, cur_mode_reg};
            IX_FILL_CHAR: idx_val = staged_reg.fill_char;
            IX_FILL_ATTR: idx_val = staged_reg.fill_attr;
            IX_WIDTH_LO:  idx_val = cur_width[7:0];
            IX_WIDTH_HI:  idx_val = {5'd0, cur_width[10:8]};
            IX_HEIGHT_LO: idx_val = cur_height[7:0];
            IX_HEIGHT_HI: idx_val = {6'd0, cur_height[9:8]};
            IX_A_BASE_LO: idx_val = active_reg.base[7:0];
            IX_A_BASE_HI: idx_val = active_reg.base[15:8];
            IX_A_CFG:     idx_val = active_reg.cfg;
            IX_A_COLS:    idx_val = active_reg.cols;
            IX_A_ROWS:    idx_val = active_reg.rows;
            IX_A_X_LO:    idx_val = active_reg.x[7:0];
            IX_A_X_HI:    idx_val = active_reg.x[15:8];
            IX_A_Y_LO:    idx_val = active_reg.y[7:0];
            IX_A_Y_HI:    idx_val = active_reg.y[15:8];
            IX_A_SCALE:   idx_val = active_reg.scale;
            IX_INFO:      idx_val = INFO_BYTE;
            default:      idx_val = 8'd0;
        endcase
    end

    always_comb
    begin
        if (off_reg[3])
        begin
            read_val = ID_BYTES[off_reg[2:0]];
        end
        else
        begin
            unique case (off_reg)
                OFF_INDEX:              read_val = reg_index_reg;
                OFF_DATA, OFF_DATA_INC: read_val = idx_val;
                OFF_STATUS:             read_val = {2'd0, status_now};
                default:                read_val = 8'd0;
            endcase
        end
    end

    assign overflow = CNT_W'(prep_reg.base) + prep_count_reg > CNT_W'(SHADOW_BYTES);
    assign arm_prod = {8'd0, staged_reg.cols} * {8'd0, staged_reg.rows};

    // snooped write window check
    assign snoop_lo  = addr_reg[15:0];
    assign snoop_pos = POS_W'(snoop_lo - armed_set_reg.base);
    assign snoop_hit = armed_reg && !busy_reg && ((addr_reg & ADDR_HI_MASK) == 32'd0)
                    && (addr_reg[16] == armed_set_reg.cfg[0])
                    && (snoop_lo >= armed_set_reg.base)
                    && (CNT_W'(snoop_pos) < armed_count_reg)
                    && (CNT_W'(snoop_pos) < CNT_W'(SHADOW_BYTES));
    assign cell_ok   = CNT_W'(cidx_reg) < CNT_W'(SHADOW_BYTES);

    assign status.finish_due = busy_reg && (cyc_reg >= ready_reg)
                            && (kind_reg == KIND_REG_READ || kind_reg == KIND_REG_WRITE
                             || kind_reg == KIND_SNOOP || kind_reg == KIND_FRAME);
    assign status.fill_ok    = !overflow;
    assign status.fill_last  = (CNT_W'(fill_cnt_reg) + CNT_W'(1)) >= armed_count_reg;
    assign status.mem_needed = (kind_reg == KIND_SNOOP && snoop_hit)
                            || (kind_reg == KIND_CELL_READ && cell_ok);

    // shadow memory ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = snoop_addr_reg;
        mem_wdata = val_reg;
        if (cmd.fill)
        begin
            mem_we    = 1'b1;
            mem_waddr = slot_addr(armed_slot_reg, fill_cnt_reg);
            mem_wdata = fill_cnt_reg[0] ? armed_set_reg.fill_attr : armed_set_reg.fill_char;
        end
        else if (cmd.mem_done && kind_reg == KIND_SNOOP && mem_rdata != val_reg)
        begin
            mem_we = 1'b1;
        end
    end

    assign mem_re    = cmd.act && status.mem_needed;
    assign mem_raddr = (kind_reg == KIND_SNOOP) ? slot_addr(armed_slot_reg, snoop_pos)
                                                : slot_addr(active_slot_reg, cidx_reg);

    tocap_ram #(
        .WIDTH (8),
        .DEPTH (SHADOW_DEPTH)
    ) u_shadow (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // state update
    always_comb
    begin
        logic     frame_dirty;
        logic     frame_vis;
        logic     do_put;
        reg_index_next   = reg_index_reg;
        staged_next      = staged_reg;
        prep_next        = prep_reg;
        armed_set_next   = armed_set_reg;
        active_next      = active_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        cur_mode_next    = cur_mode_reg;
        busy_next        = busy_reg;
        stale_next       = stale_reg;
        error_next       = error_reg;
        armed_next       = armed_reg;
        visible_next     = visible_reg;
        dirty_next       = dirty_reg;
        blink_next       = blink_reg;
        armed_slot_next  = armed_slot_reg;
        active_slot_next = active_slot_reg;
        pending_next     = pending_reg;
        ready_next       = ready_reg;
        wide_next        = wide_reg;
        gen_next         = gen_reg;
        prep_count_next  = prep_count_reg;
        armed_count_next = armed_count_reg;
        fill_cnt_next    = fill_cnt_reg;
        snoop_addr_next  = snoop_addr_reg;
        rd_next          = rd_reg;
        redraw_next      = redraw_reg;
        frame_dirty      = dirty_reg;
        frame_vis        = visible_reg;
        do_put           = 1'b0;

        if (cmd.finish)
        begin
            busy_next = 1'b0;
            if (overflow)
            begin
                error_next = 1'b1;
            end
            else
            begin
                armed_set_next   = prep_reg;
                armed_count_next = prep_count_reg;
                armed_slot_next  = !active_slot_reg;
                armed_next       = 1'b1;
                stale_next       = 1'b0;
                error_next       = 1'b0;
                fill_cnt_next    = '0;
            end
        end

        if (cmd.fill)
        begin
            fill_cnt_next = fill_cnt_reg + POS_W'(1);
        end

        if (cmd.act)
        begin
            rd_next     = 8'd0;
            redraw_next = 1'b0;
            case (kind_reg)
                KIND_REG_READ:
                begin
                    rd_next = read_val;
                    if (off_reg == OFF_DATA_INC)
                    begin
                        reg_index_next = reg_index_reg + 8'd1;
                    end
                end
                KIND_REG_WRITE:
                begin
                    case (off_reg)
                        OFF_INDEX: reg_index_next = val_reg;
                        OFF_DATA:  do_put = 1'b1;
                        OFF_DATA_INC:
                        begin
                            do_put         = 1'b1;
                            reg_index_next = reg_index_reg + 8'd1;
                        end
                        OFF_CMD:
                        begin
                            if (!busy_reg)
                            begin
                                case (val_reg)
                                    CMD_OFF: pending_next = ACT_OFF;
                                    CMD_ARM:
                                    begin
                                        if (pending_reg == ACT_NONE)
                                        begin
                                            if (staged_reg.cols == 8'd0 || staged_reg.rows == 8'd0
                                             || staged_reg.rows > ROWS_MAX
                                             || staged_reg.scale[3:0] == 4'd0
                                             || staged_reg.scale[7:4] == 4'd0
                                             || staged_reg.base < BASE_MIN
                                             || (staged_reg.cfg & CFG_RSVD_MASK) != 8'd0)
                                            begin
                                                error_next = 1'b1;
                                            end
                                            else
                                            begin
                                                prep_next       = staged_reg;
                                                prep_count_next = {arm_prod, 1'b0};
                                                busy_next       = 1'b1;
                                                ready_next      = cyc_reg + CYCLE_W'(arm_delay_reg);
                                            end
                                        end
                                    end
                                    CMD_SHOW:
                                    begin
                                        if (armed_reg && !stale_reg && !error_reg)
                                        begin
                                            pending_next = ACT_SHOW;
                                        end
                                    end
                                    CMD_HIDE: pending_next = ACT_HIDE;
                                    default:  pending_next = pending_reg;
                                endcase
                            end
                        end
                        default: reg_index_next = reg_index_reg;
                    endcase
                end
                KIND_SNOOP:
                begin
                    snoop_addr_next = slot_addr(armed_slot_reg, snoop_pos);
                end
                KIND_GAP:
                begin
                    if (armed_reg)
                    begin
                        stale_next   = 1'b1;
                        armed_next   = 1'b0;
                        pending_next = ACT_HIDE;
                    end
                end
                KIND_FRAME:
                begin
                    gen_next = gen_reg;
                    if (wide_reg != wide_in_reg)
                    begin
                        wide_next   = wide_in_reg;
                        frame_dirty = 1'b1;
                    end
                    if (pending_reg != ACT_NONE)
                    begin
                        if (pending_reg == ACT_SHOW)
                        begin
                            active_next      = armed_set_reg;
                            active_slot_next = armed_slot_reg;
                            frame_vis        = 1'b1;
                        end
                        else
                        begin
                            frame_vis = 1'b0;
                            if (pending_reg == ACT_OFF)
                            begin
                                armed_next = 1'b0;
                            end
                        end
                        pending_next = ACT_NONE;
                        frame_dirty  = 1'b1;
                        gen_next     = gen_reg + GEN_W'(1);
                    end
                    visible_next = frame_vis;
                    dirty_next   = frame_dirty;
                    if (frame_vis && (frame_dirty || blink_in_reg != blink_reg))
                    begin
                        blink_next  = blink_in_reg;
                        dirty_next  = 1'b0;
                        gen_next    = gen_next + GEN_W'(1);
                        redraw_next = 1'b1;
                    end
                end
                default: rd_next = 8'd0;
            endcase

            if (do_put)
            begin
                case (reg_index_reg)
                    IX_BASE_LO:   staged_next.base[7:0]  = val_reg;
                    IX_BASE_HI:   staged_next.base[15:8] = val_reg;
                    IX_CFG:       staged_next.cfg        = val_reg;
                    IX_COLS:      staged_next.cols       = val_reg;
                    IX_ROWS:      staged_next.rows       = val_reg;
                    IX_X_LO:      staged_next.x[7:0]     = val_reg;
                    IX_X_HI:      staged_next.x[15:8]    = val_reg;
                    IX_Y_LO:      staged_next.y[7:0]     = val_reg;
                    IX_Y_HI:      staged_next.y[15:8]    = val_reg;
                    IX_SCALE:     staged_next.scale      = val_reg;
                    IX_CUR_COL:
                    begin
                        cur_col_next = val_reg;
                        dirty_next   = 1'b1;
                    end
                    IX_CUR_ROW:
                    begin
                        cur_row_next = val_reg[6:0];
                        dirty_next   = 1'b1;
                    end
                    IX_CUR_MODE:
                    begin
                        cur_mode_next = val_reg[3:0];
                        dirty_next    = 1'b1;
                    end
                    IX_FILL_CHAR: staged_next.fill_char  = val_reg;
                    IX_FILL_ATTR: staged_next.fill_attr  = val_reg;
                    default:      staged_next            = staged_reg;
                endcase
            end
        end

        if (cmd.mem_done)
        begin
            if (kind_reg == KIND_CELL_READ)
            begin
                rd_next = mem_rdata;
            end
            else if (mem_rdata != val_reg && armed_slot_reg == active_slot_reg)
            begin
                dirty_next = 1'b1;
            end
        end
    end

    // item capture, result register and working registers, without reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg     <= kind;
            off_reg      <= offset;
            val_reg      <= value;
            addr_reg     <= address;
            cyc_reg      <= cycle;
            wide_in_reg  <= wide_canvas;
            blink_in_reg <= blink_phase;
            cidx_reg     <= cell_index;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {3'd0, cur_height, cur_width, gen_reg, redraw_reg,
                            visible_reg, status_now, rd_reg};
        end
        fill_cnt_reg   <= fill_cnt_next;
        snoop_addr_reg <= snoop_addr_next;
        rd_reg         <= rd_next;
        redraw_reg     <= redraw_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_delay_reg   <= DELAY_W'(1024);
            reg_index_reg   <= 8'd0;
            staged_reg      <= '0;
            prep_reg        <= '0;
            armed_set_reg   <= '0;
            active_reg      <= '0;
            cur_col_reg     <= 8'd0;
            cur_row_reg     <= 7'd0;
            cur_mode_reg    <= 4'd0;
            busy_reg        <= 1'b0;
            stale_reg       <= 1'b0;
            error_reg       <= 1'b0;
            armed_reg       <= 1'b0;
            visible_reg     <= 1'b0;
            dirty_reg       <= 1'b1;
            blink_reg       <= 1'b0;
            armed_slot_reg  <= 1'b0;
            active_slot_reg <= 1'b0;
            pending_reg     <= ACT_NONE;
            ready_reg       <= '0;
            wide_reg        <= 1'b0;
            gen_reg         <= GEN_W'(1);
            prep_count_reg  <= '0;
            armed_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                arm_delay_reg <= cfg_wr_data;
            end
            reg_index_reg   <= reg_index_next;
            staged_reg      <= staged_next;
            prep_reg        <= prep_next;
            armed_set_reg   <= armed_set_next;
            active_reg      <= active_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            cur_mode_reg    <= cur_mode_next;
            busy_reg        <= busy_next;
            stale_reg       <= stale_next;
            error_reg       <= error_next;
            armed_reg       <= armed_next;
            visible_reg     <= visible_next;
            dirty_reg       <= dirty_next;
            blink_reg       <= blink_next;
            armed_slot_reg  <= armed_slot_next;
            active_slot_reg <= active_slot_next;
            pending_reg     <= pending_next;
            ready_reg       <= ready_next;
            wide_reg        <= wide_next;
            gen_reg         <= gen_next;
            prep_count_reg  <= prep_count_next;
            armed_count_reg <= armed_count_next;
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

/* src/text_overlay_register_capture_top.sv */
`timescale 1ns / 1ps
// flow: each item is captured, executed and acted on, and its result loaded into
//   the output register; snooped writes that hit the window and cell reads add
//   a shadow ram read; when a transfer ends the busy window and the setup fits,
//   the fill sweep runs first and writes 2*cols*rows bytes, one byte a cycle
// items: one at a time; a new transfer is taken once the last result is loaded
// reset: rst_n async, clears state and flags; shadow ram, item regs not cleared
// ----------------------------------------------------------------------------
// text_overlay_register_capture_top
// text overlay card controller: registers, arm and fill, snoop capture, frames
// ----------------------------------------------------------------------------
module text_overlay_register_capture_top
    import tocap_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input item channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // offset, value, address, cycle, wide_canvas, blink_phase, cell_index, pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [2:0]            s_tuser,
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_data, status_bits, is_visible, redraw, generation, canvas_width,
    // canvas_height, pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // arm_delay register
    input  logic                  cfg_wr_en,
    input  logic [DELAY_W-1:0]    cfg_wr_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: one item at a time, result held in an output register so the
    // next transfer is taken while the result waits
    tocap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath with field unpacking of the input transfer
    tocap_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (s_tuser),
        .offset      (s_tdata[3:0]),
        .value       (s_tdata[11:4]),
        .address     (s_tdata[43:12]),
        .cycle       (s_tdata[107:44]),
        .wide_canvas (s_tdata[108]),
        .blink_phase (s_tdata[109]),
        .cell_index  (s_tdata[125:110]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata)
    );

endmodule

/* src/tocap_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tocap_checker
// port level checks on the overlay block, bound to the top level
// ----------------------------------------------------------------------------
module tocap_checker
    import tocap_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while busy");

    // visible status bit matches the visible field
    a_vis: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[8] == m_tdata[14])
        else $error("status visible bit mismatch");

    // redraw only when visible
    a_redraw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15] |-> m_tdata[14])
        else $error("redraw while hidden");

    // canvas size is one of the two modes
    a_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[58:48] == WIDTH_WIDE && m_tdata[68:59] == HEIGHT_WIDE)
                  || (m_tdata[58:48] == WIDTH_NARROW && m_tdata[68:59] == HEIGHT_NARROW))
        else $error("bad canvas size");

endmodule

bind text_overlay_register_capture_top tocap_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
